[rtl/gacc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gacc_pkg: shared types and constants
// Item and result layouts, register indexes, state codes and the command and
// status groups between the controller and the datapath of the gamepad
// arming command conditioner.
// ----------------------------------------------------------------------------
package gacc_pkg;

    // Tick counter width default and battery charging code
    localparam int          TICK_COUNTER_WIDTH = 16;
    localparam logic [7:0]  CHARGING_CODE      = 8'd238;

    // Item modes
    localparam logic [1:0]  MODE_REPORT  = 2'd0;
    localparam logic [1:0]  MODE_TICK    = 2'd1;
    localparam logic [1:0]  MODE_CONNECT = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W         = 3;
    localparam int          CFG_DATA_W        = 16;
    localparam logic [2:0]  CFG_DEADBAND      = 3'd0;
    localparam logic [2:0]  CFG_FULL_SCALE    = 3'd1;
    localparam logic [2:0]  CFG_ARM_HOLD      = 3'd2;
    localparam logic [2:0]  CFG_LINK_TIMEOUT  = 3'd3;
    localparam logic [2:0]  CFG_RESTART       = 3'd4;

    // Register reset values
    localparam logic [6:0]  DEADBAND_RST      = 7'd10;
    localparam logic [7:0]  FULL_SCALE_RST    = 8'd100;
    localparam logic [15:0] ARM_HOLD_RST      = 16'd2000;
    localparam logic [15:0] LINK_TIMEOUT_RST  = 16'd200;
    localparam logic [15:0] RESTART_RST       = 16'd2000;

    // Scaling constants
    localparam logic [6:0]  PCT_MAX           = 7'd100;
    localparam logic [7:0]  BATT_STEP         = 8'd25;
    localparam logic [7:0]  BATT_CHARGING     = 8'hFF;   // -1
    localparam logic [7:0]  BATT_LINK_LOST    = 8'hFE;   // -2
    localparam logic [2:0]  DIV_LAST_STEP     = 3'd6;    // seven quotient bits

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [7:0] left_x;
        logic signed [7:0] left_y;
        logic signed [7:0] right_x;
        logic signed [7:0] right_y;
        logic              disarm_button;
        logic              arm_button_a;
        logic              arm_button_b;
        logic [7:0]        battery_code;
    } t_item;

    typedef struct packed {
        logic signed [7:0] body_forward;
        logic signed [7:0] body_tilt;
        logic signed [7:0] neck_forward;
        logic signed [7:0] neck_tilt;
        logic              armed;
        logic signed [7:0] battery_percent;
        logic              link_lost;
        logic              restart_request;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PREP,
        S_DIV,
        S_STORE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic prep;
        logic div_step;
        logic store;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_report;
        logic armed;
        logic use_div;
        logic step_last;
        logic axis_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

[rtl/gacc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gacc_ctrl: sequencing controller
// Steps one item through update, per-axis scaling with the shared divider,
// and hand-off to the output register.
// ----------------------------------------------------------------------------
module gacc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire gacc_pkg::t_status i_status,
    output gacc_pkg::t_cmd         o_cmd
);

    gacc_pkg::t_state r_state;
    gacc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gacc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            gacc_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = gacc_pkg::S_EXEC;
                end
            end
            gacc_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.is_report ? gacc_pkg::S_PREP : gacc_pkg::S_DONE;
            end
            gacc_pkg::S_PREP: begin
                // Skip scaling when the report left the block disarmed
                if (i_status.armed) begin
                    o_cmd.prep = 1'b1;
                    n_state    = gacc_pkg::S_DIV;
                end else begin
                    n_state    = gacc_pkg::S_DONE;
                end
            end
            gacc_pkg::S_DIV: begin
                if (i_status.use_div) begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.step_last) begin
                        n_state = gacc_pkg::S_STORE;
                    end
                end else begin
                    n_state = gacc_pkg::S_STORE;
                end
            end
            gacc_pkg::S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_status.axis_last ? gacc_pkg::S_DONE : gacc_pkg::S_PREP;
            end
            gacc_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = gacc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gacc_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/gacc_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gacc_dp: conditioner datapath
// Configuration registers, arming and link state, axis offsets and commands,
// a shared bit-serial divider for axis scaling, and the output register.
// ----------------------------------------------------------------------------
module gacc_dp #(
    parameter int TICK_COUNTER_WIDTH = gacc_pkg::TICK_COUNTER_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gacc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gacc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire gacc_pkg::t_item                 i_in_item,
    input  wire gacc_pkg::t_cmd                  i_cmd,
    output gacc_pkg::t_status                    o_status,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output gacc_pkg::t_result                    o_out_result
);

    localparam int W     = TICK_COUNTER_WIDTH;
    localparam int CMP_W = (W > 16) ? W : 16;

    localparam logic [14:0] PCT_MAX_15 = 15'(gacc_pkg::PCT_MAX);

    // Configuration
    logic [6:0]  r_deadband;
    logic [7:0]  r_full_scale;
    logic [15:0] r_arm_hold;
    logic [15:0] r_link_to;
    logic [15:0] r_restart_to;

    // Item and block state
    gacc_pkg::t_item   r_item;
    logic              r_armed,     n_armed;
    logic              r_pending,   n_pending;
    logic [W-1:0]      r_hold,      n_hold;
    logic [W-1:0]      r_sil,       n_sil;
    logic              r_link_up,   n_link_up;
    logic              r_timed_out, n_timed_out;
    logic              r_restart,   n_restart;
    logic [7:0]        r_batt,      n_batt;
    logic signed [8:0] r_off [4];
    logic signed [8:0] n_off [4];
    logic signed [7:0] r_cmd [4];
    logic signed [7:0] n_cmd [4];

    // Axis loop and divider
    logic [1:0]  r_axis, n_axis;
    logic [2:0]  r_step, n_step;
    logic [13:0] r_rem,  n_rem;
    logic [13:0] r_dsr,  n_dsr;
    logic [6:0]  r_q,    n_q;
    logic        r_neg,  n_neg;
    logic        r_use_div, n_use_div;

    // Output register
    gacc_pkg::t_result r_out;
    logic              r_out_valid;

    // Combinational helpers
    logic signed [8:0] w_ax [4];
    logic signed [9:0] w_v;
    logic [9:0]        w_vabs;
    logic [8:0]        w_mag;
    logic [8:0]        w_diff;
    logic [14:0]       w_prod;
    logic [7:0]        w_den;
    logic [W-1:0]      w_hold_inc;
    logic [W-1:0]      w_sil_inc;
    logic [7:0]        w_batt;
    logic [7:0]        w_qext;

    // Body forward and neck forward are the negated vertical sticks
    assign w_ax[0] = -$signed({r_item.left_y[7], r_item.left_y});
    assign w_ax[1] = $signed({r_item.left_x[7], r_item.left_x});
    assign w_ax[2] = -$signed({r_item.right_y[7], r_item.right_y});
    assign w_ax[3] = $signed({r_item.right_x[7], r_item.right_x});

    assign w_v    = $signed({w_ax[r_axis][8], w_ax[r_axis]})
                  - $signed({r_off[r_axis][8], r_off[r_axis]});
    assign w_vabs = w_v[9] ? 10'(-w_v) : w_v;
    assign w_mag  = w_vabs[8:0];
    assign w_diff = w_mag - {2'b00, r_deadband};
    assign w_prod = w_diff[7:0] * PCT_MAX_15;
    assign w_den  = r_full_scale - {1'b0, r_deadband};

    assign w_hold_inc = (r_hold == {W{1'b1}}) ? r_hold : r_hold + W'(1);
    assign w_sil_inc  = (r_sil  == {W{1'b1}}) ? r_sil  : r_sil  + W'(1);
    assign w_qext     = {1'b0, r_q};

    // Battery code to percent: charging flag, else (code - 1) * 25 in 0..100
    always_comb begin
        if (r_item.battery_code == gacc_pkg::CHARGING_CODE) begin
            w_batt = gacc_pkg::BATT_CHARGING;
        end else if (r_item.battery_code <= 8'd1) begin
            w_batt = 8'd0;
        end else if (r_item.battery_code >= 8'd5) begin
            w_batt = 8'(gacc_pkg::PCT_MAX);
        end else begin
            w_batt = 8'((r_item.battery_code - 8'd1) * gacc_pkg::BATT_STEP);
        end
    end

    always_comb begin
        n_armed     = r_armed;
        n_pending   = r_pending;
        n_hold      = r_hold;
        n_sil       = r_sil;
        n_link_up   = r_link_up;
        n_timed_out = r_timed_out;
        n_restart   = r_restart;
        n_batt      = r_batt;
        n_off       = r_off;
        n_cmd       = r_cmd;
        n_axis      = r_axis;
        n_step      = r_step;
        n_rem       = r_rem;
        n_dsr       = r_dsr;
        n_q         = r_q;
        n_neg       = r_neg;
        n_use_div   = r_use_div;

        if (i_cmd.exec) begin
            n_restart = 1'b0;
            n_axis    = 2'd0;
            case (r_item.mode)
                gacc_pkg::MODE_REPORT: begin
                    if (r_armed) begin
                        if (r_item.disarm_button) begin
                            n_armed = 1'b0;
                            n_cmd   = '{default: 8'sd0};
                        end
                    end else if (r_item.arm_button_a && r_item.arm_button_b) begin
                        if (r_pending) begin
                            if (CMP_W'(r_hold) >= CMP_W'(r_arm_hold)) begin
                                n_armed   = 1'b1;
                                n_off     = w_ax;
                                n_pending = 1'b0;
                            end
                        end else begin
                            n_pending = 1'b1;
                            n_hold    = '0;
                        end
                    end else begin
                        n_pending = 1'b0;
                    end
                    n_batt      = w_batt;
                    n_sil       = '0;
                    n_timed_out = 1'b0;
                end
                gacc_pkg::MODE_TICK: begin
                    if (r_pending) begin
                        n_hold = w_hold_inc;
                    end
                    n_sil = w_sil_inc;
                    if (r_link_up) begin
                        if (!r_timed_out) begin
                            if (CMP_W'(w_sil_inc) > CMP_W'(r_link_to)) begin
                                n_timed_out = 1'b1;
                                n_armed     = 1'b0;
                                n_cmd       = '{default: 8'sd0};
                                n_batt      = gacc_pkg::BATT_LINK_LOST;
                            end
                        end else if (CMP_W'(w_sil_inc) > CMP_W'(r_restart_to)) begin
                            n_restart = 1'b1;
                        end
                    end
                end
                gacc_pkg::MODE_CONNECT: begin
                    n_sil     = '0;
                    n_link_up = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // Classify the axis: zero inside deadband, saturate, or divide
        if (i_cmd.prep) begin
            n_neg     = w_v[9];
            n_use_div = 1'b0;
            n_q       = 7'd0;
            n_rem     = w_prod[13:0];
            n_dsr     = {w_den, 6'b0};
            n_step    = gacc_pkg::DIV_LAST_STEP;
            if (w_mag <= {2'b00, r_deadband}) begin
                n_q = 7'd0;
            end else if (w_mag > {1'b0, r_full_scale}) begin
                n_q = gacc_pkg::PCT_MAX;
            end else if (r_full_scale <= {1'b0, r_deadband}) begin
                n_q = gacc_pkg::PCT_MAX;
            end else begin
                n_use_div = 1'b1;
            end
        end

        // One restoring quotient bit per step
        if (i_cmd.div_step) begin
            if (r_rem >= r_dsr) begin
                n_rem = r_rem - r_dsr;
                n_q   = {r_q[5:0], 1'b1};
            end else begin
                n_q   = {r_q[5:0], 1'b0};
            end
            n_dsr  = {1'b0, r_dsr[13:1]};
            n_step = r_step - 3'd1;
        end

        if (i_cmd.store) begin
            n_cmd[r_axis] = r_neg ? -$signed(w_qext) : $signed(w_qext);
            n_axis        = r_axis + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband   <= gacc_pkg::DEADBAND_RST;
            r_full_scale <= gacc_pkg::FULL_SCALE_RST;
            r_arm_hold   <= gacc_pkg::ARM_HOLD_RST;
            r_link_to    <= gacc_pkg::LINK_TIMEOUT_RST;
            r_restart_to <= gacc_pkg::RESTART_RST;
            r_armed      <= 1'b0;
            r_pending    <= 1'b0;
            r_hold       <= '0;
            r_sil        <= '0;
            r_link_up    <= 1'b0;
            r_timed_out  <= 1'b1;
            r_restart    <= 1'b0;
            r_batt       <= 8'd0;
            r_off        <= '{default: 9'sd0};
            r_cmd        <= '{default: 8'sd0};
            r_axis       <= 2'd0;
            r_step       <= 3'd0;
            r_use_div    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gacc_pkg::CFG_DEADBAND:     r_deadband   <= i_cfg_data[6:0];
                    gacc_pkg::CFG_FULL_SCALE:   r_full_scale <= i_cfg_data[7:0];
                    gacc_pkg::CFG_ARM_HOLD:     r_arm_hold   <= i_cfg_data;
                    gacc_pkg::CFG_LINK_TIMEOUT: r_link_to    <= i_cfg_data;
                    gacc_pkg::CFG_RESTART:      r_restart_to <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_armed     <= n_armed;
            r_pending   <= n_pending;
            r_hold      <= n_hold;
            r_sil       <= n_sil;
            r_link_up   <= n_link_up;
            r_timed_out <= n_timed_out;
            r_restart   <= n_restart;
            r_batt      <= n_batt;
            r_off       <= n_off;
            r_cmd       <= n_cmd;
            r_axis      <= n_axis;
            r_step      <= n_step;
            r_use_div   <= n_use_div;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_q   <= n_q;
        r_neg <= n_neg;
        if (i_cmd.load_out) begin
            r_out.body_forward    <= r_cmd[0];
            r_out.body_tilt       <= r_cmd[1];
            r_out.neck_forward    <= r_cmd[2];
            r_out.neck_tilt       <= r_cmd[3];
            r_out.armed           <= r_armed;
            r_out.battery_percent <= $signed(r_batt);
            r_out.link_lost       <= r_timed_out;
            r_out.restart_request <= r_restart;
        end
    end

    assign o_status.is_report = (r_item.mode == gacc_pkg::MODE_REPORT);
    assign o_status.armed     = r_armed;
    assign o_status.use_div   = r_use_div;
    assign o_status.step_last = (r_step == 3'd0);
    assign o_status.axis_last = (r_axis == 2'd3);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

endmodule
`default_nettype wire

[rtl/gamepad_arming_command_conditioner_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_arming_command_conditioner_unit: gamepad arming and stick scaling
// Takes gamepad reports, ticks and connect events; arms on a held button
// combination, scales four offset-corrected sticks to percent commands,
// maps battery codes and watches the link for silence.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ----------------------------
//  in        input      i_in_valid / o_in_stall   i_in_item    (t_item)
//  out       output     o_out_valid / i_out_stall o_out_result (t_result)
//  cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  Every item gives exactly one result. A tick or connect event passes the
//  execute and done states; a report also passes the prep state, and while
//  armed each of the four axes runs through one shared restoring divider
//  when it lands between deadband and limit, and is then stored.
//  One item is in flight at a time; the next is taken as soon as the result
//  sits in the output register, even while the far side stalls it.
//  Reset is synchronous, active low; it clears the control state and loads
//  the default configuration. No clearing pass is needed.
//
module gamepad_arming_command_conditioner_unit #(
    parameter int TICK_COUNTER_WIDTH = gacc_pkg::TICK_COUNTER_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input items
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire gacc_pkg::t_item                 i_in_item,
    // Results
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output gacc_pkg::t_result                    o_out_result,
    // Configuration writes
    input  wire logic                            i_cfg_we,
    input  wire logic [gacc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gacc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Controller drives commands, datapath answers with status
    gacc_pkg::t_cmd    w_cmd;
    gacc_pkg::t_status w_status;

    gacc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath holds the arming, link and axis state, the divider and the output register
    gacc_dp #(
        .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_item    (i_in_item),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result)
    );

`ifndef SYNTHESIS
    // Arming happens only on a report, which clears the timeout
    a_armed_link_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_result.armed) |-> !o_out_result.link_lost)
        else $error("armed result while link is lost");

    // Disarmed means all commands are zero
    a_disarmed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_result.armed) |->
            (o_out_result.body_forward == 8'sd0) && (o_out_result.body_tilt == 8'sd0) &&
            (o_out_result.neck_forward == 8'sd0) && (o_out_result.neck_tilt == 8'sd0))
        else $error("nonzero command while disarmed");

    // Restart is only requested after the link has timed out
    a_restart_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_result.restart_request) |-> o_out_result.link_lost)
        else $error("restart requested while link is up");

    // Body forward and neck tilt commands stay within plus or minus 100
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_result.body_forward <= 8'sd100) && (o_out_result.body_forward >= -8'sd100) &&
            (o_out_result.neck_tilt <= 8'sd100) && (o_out_result.neck_tilt >= -8'sd100))
        else $error("command out of range");
`endif

endmodule
`default_nettype wire

[tb/sv/tb_gamepad_arming_command_conditioner_unit.sv]
// ----------------------------------------------------------------------------
// tb_gamepad_arming_command_conditioner_unit: self-checking bench
// Drives reports, ticks and connect events into the conditioner through the
// valid/stall item channel. A behavioral copy of the arming, stick scaling,
// battery and link logic predicts one command set per accepted item. Every
// accepted result is checked field by field against the oldest prediction.
// A directed opening is followed by randomized arming sessions, silences and
// noise over several register settings. A tick run at the end holds the
// hold and link limits at the counter's maximum.
// ----------------------------------------------------------------------------
module tb_gamepad_arming_command_conditioner_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import gacc_pkg::*;

    localparam int         CNT_W             = TICK_COUNTER_WIDTH;
    localparam logic [1:0] MODE_UNUSED       = 2'd3;
    localparam int         ITEMS_PER_SETTING = 225;
    localparam int         HOLDOFF_CYCLES    = 400;
    localparam int         SETTLE_CYCLES     = 60;
    localparam int         END_TICKS         = 40;
    localparam int         TICK_RUN_CAP      = 30;

    // ------------------------------------------------------------------
    // Block ports, all at known values from time zero
    // ------------------------------------------------------------------
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    t_item                 i_in_item    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    t_result               o_out_result;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    gamepad_arming_command_conditioner_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------
    t_item   event_backlog[$];     // items waiting for the driver
    t_result command_backlog[$];   // predicted results, oldest first
    int      queued_count    = 0;
    int      accepted_count  = 0;
    int      results_seen    = 0;
    int      mismatches      = 0;
    int      send_idle_pct   = 0;
    int      recv_idle_pct   = 0;
    bit      item_taken      = 1'b0;
    bit      holdoff_request = 1'b0;
    int      holdoff_left    = 0;

    // ------------------------------------------------------------------
    // Behavioral copy of the conditioner: configuration and state
    // ------------------------------------------------------------------
    logic [6:0]        deadband_cfg     = DEADBAND_RST;
    logic [7:0]        full_scale_cfg   = FULL_SCALE_RST;
    logic [15:0]       arm_hold_cfg     = ARM_HOLD_RST;
    logic [15:0]       link_timeout_cfg = LINK_TIMEOUT_RST;
    logic [15:0]       restart_cfg      = RESTART_RST;

    logic              arm_state   = 1'b0;
    logic              arm_wait    = 1'b0;
    logic [CNT_W-1:0]  hold_count  = '0;
    int                stick_zero[4] = '{0, 0, 0, 0};
    int                axis_cmd[4]   = '{0, 0, 0, 0};
    logic signed [7:0] battery_pct = '0;
    logic              link_seen   = 1'b0;
    logic              link_down   = 1'b1;   // no report seen yet
    logic [CNT_W-1:0]  quiet_count = '0;

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // Deadband, limit and percent scaling of one offset-corrected axis
    function automatic int axis_percent(int v);
        int d, f, mag, q;
        d   = int'(deadband_cfg);
        f   = int'(full_scale_cfg);
        mag = (v < 0) ? -v : v;
        if (mag <= d) return 0;
        if (v > f) return int'(PCT_MAX);
        if (v < -f) return -int'(PCT_MAX);
        // limit at or under the deadband: saturate outside the deadband
        if (f <= d) return (v < 0) ? -int'(PCT_MAX) : int'(PCT_MAX);
        q = ((mag - d) * int'(PCT_MAX)) / (f - d);
        return (v < 0) ? -q : q;
    endfunction

    function automatic void drop_arm();
        arm_state = 1'b0;
        for (int i = 0; i < 4; i++) axis_cmd[i] = 0;
    endfunction

    // Advance the state by one item and return the command set it yields
    function automatic t_result condition_event(t_item it);
        int      ax[4];
        int      b;
        logic    restart_now;
        t_result r;
        restart_now = 1'b0;
        ax[0] = -int'($signed(it.left_y));
        ax[1] =  int'($signed(it.left_x));
        ax[2] = -int'($signed(it.right_y));
        ax[3] =  int'($signed(it.right_x));
        case (it.mode)
            MODE_REPORT: begin
                if (arm_state) begin
                    if (it.disarm_button) drop_arm();
                end else if (it.arm_button_a && it.arm_button_b) begin
                    if (!arm_wait) begin
                        arm_wait   = 1'b1;
                        hold_count = '0;
                    end else if (hold_count >= arm_hold_cfg) begin
                        arm_state  = 1'b1;
                        stick_zero = ax;
                        arm_wait   = 1'b0;
                    end
                end else begin
                    arm_wait = 1'b0;
                end
                if (arm_state) begin
                    for (int i = 0; i < 4; i++) axis_cmd[i] = axis_percent(ax[i] - stick_zero[i]);
                end
                if (it.battery_code == CHARGING_CODE) begin
                    battery_pct = BATT_CHARGING;
                end else begin
                    b = (int'(it.battery_code) - 1) * int'(BATT_STEP);
                    if (b < 0) b = 0;
                    if (b > int'(PCT_MAX)) b = int'(PCT_MAX);
                    battery_pct = 8'(b);
                end
                quiet_count = '0;
                link_down   = 1'b0;
            end
            MODE_TICK: begin
                if (arm_wait) hold_count = bump(hold_count);
                quiet_count = bump(quiet_count);
                if (link_seen) begin
                    if (!link_down) begin
                        if (quiet_count > link_timeout_cfg) begin
                            link_down   = 1'b1;
                            drop_arm();
                            battery_pct = BATT_LINK_LOST;
                        end
                    end else if (quiet_count > restart_cfg) begin
                        restart_now = 1'b1;
                    end
                end
            end
            MODE_CONNECT: begin
                quiet_count = '0;
                link_seen   = 1'b1;
            end
            default: ;
        endcase
        r.body_forward    = 8'(axis_cmd[0]);
        r.body_tilt       = 8'(axis_cmd[1]);
        r.neck_forward    = 8'(axis_cmd[2]);
        r.neck_tilt       = 8'(axis_cmd[3]);
        r.armed           = arm_state;
        r.battery_percent = battery_pct;
        r.link_lost       = link_down;
        r.restart_request = restart_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string field, int got, int want);
        mismatches++;
        $display("mismatch at result %0d: %s got %0d want %0d",
                 results_seen, field, got, want);
    endtask

    task automatic compare_command(t_result got, t_result want);
        if (got.body_forward !== want.body_forward)
            flag_mismatch("body_forward", int'(got.body_forward), int'(want.body_forward));
        if (got.body_tilt !== want.body_tilt)
            flag_mismatch("body_tilt", int'(got.body_tilt), int'(want.body_tilt));
        if (got.neck_forward !== want.neck_forward)
            flag_mismatch("neck_forward", int'(got.neck_forward), int'(want.neck_forward));
        if (got.neck_tilt !== want.neck_tilt)
            flag_mismatch("neck_tilt", int'(got.neck_tilt), int'(want.neck_tilt));
        if (got.armed !== want.armed)
            flag_mismatch("armed", int'(got.armed), int'(want.armed));
        if (got.battery_percent !== want.battery_percent)
            flag_mismatch("battery_percent", int'(got.battery_percent),
                          int'(want.battery_percent));
        if (got.link_lost !== want.link_lost)
            flag_mismatch("link_lost", int'(got.link_lost), int'(want.link_lost));
        if (got.restart_request !== want.restart_request)
            flag_mismatch("restart_request", int'(got.restart_request),
                          int'(want.restart_request));
    endtask

    // Sample both handshakes at the rising edge. Check the result first: a
    // result can never belong to the item accepted at the same edge.
    always @(posedge i_clk) begin
        item_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (command_backlog.size() == 0)
                    flag_mismatch("result with nothing pending", 0, 0);
                else
                    compare_command(o_out_result, command_backlog.pop_front());
            end
            if (i_in_valid && !o_in_stall) begin
                command_backlog.push_back(condition_event(i_in_item));
                accepted_count++;
                item_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: advance to the next item only once the current one is taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_in_valid || item_taken) begin
            if (i_rst_n && event_backlog.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_item  <= event_backlog.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (holdoff_request) begin
            holdoff_left    = HOLDOFF_CYCLES;
            holdoff_request = 1'b0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic enqueue(t_item it);
        event_backlog.push_back(it);
        queued_count++;
    endtask

    function automatic t_item noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_item)-1:0];
    endfunction

    // Item of the given mode with random filler in the unused fields
    function automatic t_item filler(logic [1:0] mode);
        t_item it;
        it      = noise_item();
        it.mode = mode;
        return it;
    endfunction

    function automatic logic [7:0] random_battery();
        case ($urandom_range(0, 5))
            0:       return CHARGING_CODE;
            1:       return 8'($urandom_range(0, 6));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] small_stick();
        return 8'(int'($urandom_range(0, 40)) - 20);
    endfunction

    function automatic t_item random_report(logic a, logic b, logic disarm);
        t_item it;
        it = noise_item();
        it.mode = MODE_REPORT;
        // keep the sticks near center now and then so the deadband is hit
        if ($urandom_range(0, 3) == 0) begin
            it.left_x  = small_stick();
            it.left_y  = small_stick();
            it.right_x = small_stick();
            it.right_y = small_stick();
        end
        it.disarm_button = disarm;
        it.arm_button_a  = a;
        it.arm_button_b  = b;
        it.battery_code  = random_battery();
        return it;
    endfunction

    function automatic t_item make_report(int lx, int ly, int rx, int ry,
                                          logic disarm, logic a, logic b, int batt);
        t_item it;
        it.mode          = MODE_REPORT;
        it.left_x        = 8'(lx);
        it.left_y        = 8'(ly);
        it.right_x       = 8'(rx);
        it.right_y       = 8'(ry);
        it.disarm_button = disarm;
        it.arm_button_a  = a;
        it.arm_button_b  = b;
        it.battery_code  = 8'(batt);
        return it;
    endfunction

    // Register writes only while the block is idle
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_DEADBAND:     deadband_cfg     = val[6:0];
            CFG_FULL_SCALE:   full_scale_cfg   = val[7:0];
            CFG_ARM_HOLD:     arm_hold_cfg     = val;
            CFG_LINK_TIMEOUT: link_timeout_cfg = val;
            CFG_RESTART:      restart_cfg      = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(int d, int f, int h, int l, int r);
        write_register(CFG_DEADBAND,     16'(d));
        write_register(CFG_FULL_SCALE,   16'(f));
        write_register(CFG_ARM_HOLD,     16'(h));
        write_register(CFG_LINK_TIMEOUT, 16'(l));
        write_register(CFG_RESTART,      16'(r));
    endtask

    // Hold off the sender until every pending item has its result
    task automatic drain();
        do @(negedge i_clk);
        while (accepted_count != queued_count || command_backlog.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // One random stretch: an arming session, a silence, or plain noise
    task automatic queue_random_session();
        int kind, n, cap;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            if ($urandom_range(0, 1)) enqueue(filler(MODE_CONNECT));
            enqueue(random_report(1'b1, 1'b1, 1'b0));
            // hold just short of, at, or past the arm time
            n = int'(arm_hold_cfg) - 1 + int'($urandom_range(0, 3));
            if (n < 0) n = 0;
            if (n > TICK_RUN_CAP) n = TICK_RUN_CAP;
            repeat (n) enqueue(filler(MODE_TICK));
            enqueue(random_report(1'b1, 1'b1, 1'b0));
            n = $urandom_range(4, 20);
            repeat (n) begin
                case ($urandom_range(0, 11))
                    0:       enqueue(random_report(1'($urandom), 1'($urandom), 1'b1));
                    1:       enqueue(filler(MODE_TICK));
                    default: enqueue(random_report(1'($urandom), 1'($urandom), 1'b0));
                endcase
            end
        end else if (kind < 7) begin
            if ($urandom_range(0, 1)) enqueue(filler(MODE_CONNECT));
            if ($urandom_range(0, 1)) enqueue(random_report(1'b0, 1'b0, 1'b0));
            cap = int'((link_timeout_cfg > restart_cfg) ? link_timeout_cfg : restart_cfg) + 3;
            if (cap > TICK_RUN_CAP) cap = TICK_RUN_CAP;
            n = $urandom_range(0, cap);
            repeat (n) enqueue(filler(MODE_TICK));
        end else begin
            n = $urandom_range(3, 10);
            repeat (n) enqueue(noise_item());
        end
    endtask

    task automatic run_setting(int d, int f, int h, int l, int r, bit with_holdoff);
        int start;
        apply_setting(d, f, h, l, r);
        start = queued_count;
        while (queued_count - start < ITEMS_PER_SETTING) queue_random_session();
        // stall the result side for a long stretch while items keep coming
        if (with_holdoff) holdoff_request = 1'b1;
        drain();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 19;
        recv_idle_pct = 72;

        // Directed opening: short hold and timeouts
        apply_setting(10, 100, 2, 3, 5);
        enqueue(filler(MODE_TICK));                          // tick before any connect
        enqueue(make_report(0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 238)); // charging code
        enqueue(make_report(0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 0));   // clamp low
        enqueue(make_report(0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 255)); // clamp high
        enqueue(make_report(0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 2));
        enqueue(filler(MODE_UNUSED));
        enqueue(filler(MODE_CONNECT));
        // start the combination, hold for two ticks, then arm
        enqueue(make_report(-128, 0, 0, 127, 1'b0, 1'b1, 1'b1, 100));
        enqueue(filler(MODE_TICK));
        enqueue(filler(MODE_TICK));
        enqueue(make_report(-128, 0, 0, 127, 1'b0, 1'b1, 1'b1, 100));
        // full-range swings away from the captured offsets
        enqueue(make_report(127, -128, -128, -128, 1'b0, 1'b0, 1'b0, 1));
        // inside the scaling range, and one axis exactly at the deadband
        enqueue(make_report(-98, -50, -10, 116, 1'b0, 1'b0, 1'b0, 5));
        enqueue(make_report(50, 50, 50, 50, 1'b1, 1'b0, 1'b0, 3));   // disarm
        enqueue(make_report(0, 0, 0, 0, 1'b0, 1'b1, 1'b0, 4));       // half combination
        // silence past the link timeout, then past the restart limit
        repeat (6) enqueue(filler(MODE_TICK));
        enqueue(filler(MODE_CONNECT));
        enqueue(filler(MODE_TICK));
        drain();

        // Sender idles lightly, receiver heavily
        run_setting(10, 100, 3, 6, 12, 1'b1);
        run_setting(0, 128, 0, 0, 0, 1'b0);
        run_setting(127, 1, 1, 4, 4, 1'b0);

        // Sender idles heavily, receiver lightly
        send_idle_pct = 72;
        recv_idle_pct = 19;
        run_setting(40, 90, 2, 10, 20, 1'b1);
        run_setting(50, 50, 5, 3, 65535, 1'b0);
        run_setting(0, 1, 0, 2, 5, 1'b0);

        // No idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(127, 128, 4, 8, 16, 1'b1);
        run_setting(20, 60, 1, 5, 9, 1'b0);

        // Limits at the counter's maximum: a short silence never times out
        // and a short hold never arms.
        apply_setting(10, 100, 65535, 65535, 65535);
        enqueue(filler(MODE_CONNECT));
        enqueue(random_report(1'b1, 1'b1, 1'b0));
        repeat (END_TICKS) enqueue(filler(MODE_TICK));
        enqueue(random_report(1'b1, 1'b1, 1'b0));
        repeat (6) enqueue(random_report(1'b0, 1'b0, 1'b0));
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (command_backlog.size() != 0)
            flag_mismatch("results never delivered", command_backlog.size(), 0);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
